// ----- design/bpm_pkg.sv -----
// Shared types and constants for the barycentric point mapper.
// Item structs, action codes and table sizes; no dependencies.
`timescale 1ns / 1ps
package bpm_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_FACES    = 1024;
    localparam int COORD_BITS   = 24;
    localparam int VTX_AW       = $clog2(MAX_VERTICES);
    localparam int FACE_AW      = $clog2(MAX_FACES);
    localparam int FCNT_W       = 11;
    localparam int WFRAC        = 24;

    typedef enum logic [1:0] {
        ACT_REST  = 2'd0,
        ACT_DEF   = 2'd1,
        ACT_FACE  = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef struct packed {
        t_action                        action;
        logic [9:0]                     index;
        logic signed [COORD_BITS-1:0]   coord_x;
        logic signed [COORD_BITS-1:0]   coord_y;
        logic signed [COORD_BITS-1:0]   coord_z;
        logic [9:0]                     corner_a;
        logic [9:0]                     corner_b;
        logic [9:0]                     corner_c;
    } t_in_item;

    typedef struct packed {
        logic                           found;
        logic signed [COORD_BITS-1:0]   mapped_x;
        logic signed [COORD_BITS-1:0]   mapped_y;
        logic signed [COORD_BITS-1:0]   mapped_z;
    } t_out_item;

endpackage

// ----- design/barycentric_point_mapper_unit.sv -----
// Barycentric point mapper top level: mesh tables in three RAMs and a query sequencer.
// Depends on bpm_pkg for item types, action codes and table sizes.
// A load item writes its table entry from idle. A query scans faces in order until one
// contains the point, each face taking a face read, three rest vertex reads, six
// multiplies on the shared multiplier and a sign test, then runs three restoring
// divisions, three deformed vertex reads and a nine-multiply blend.
// Throughput: one item at a time. Reset clears control state and face_count;
// the tables are undefined until written.
`timescale 1ns / 1ps
module barycentric_point_mapper_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bpm_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bpm_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bpm_pkg::FCNT_W-1:0]     i_cfg_data
);
    import bpm_pkg::*;

    localparam int DW = 52;  // determinant and blend accumulator width
    localparam int WW = WFRAC + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_FACE, S_VA, S_VB, S_VC, S_VD, S_DET, S_TEST,
        S_DIV, S_DA, S_DB, S_DC, S_DD, S_BLEND, S_DONE
    } t_state;

    // Tables
    logic [2*COORD_BITS-1:0] rest_mem [MAX_VERTICES];
    logic [3*COORD_BITS-1:0] def_mem  [MAX_VERTICES];
    logic [3*VTX_AW-1:0]     face_mem [MAX_FACES];
    logic [2*COORD_BITS-1:0] r_rest_q;
    logic [3*COORD_BITS-1:0] r_def_q;
    logic [3*VTX_AW-1:0]     r_face_q;
    logic [VTX_AW-1:0]       rest_addr;
    logic [VTX_AW-1:0]       def_addr;

    t_state                   r_state;
    logic [FCNT_W-1:0]        r_fc;
    logic [FCNT_W-1:0]        r_nfaces;
    logic [FACE_AW-1:0]       r_face;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [VTX_AW-1:0]        r_ca, r_cb, r_cc;
    logic [2*COORD_BITS-1:0]  r_v  [3];
    logic [3*COORD_BITS-1:0]  r_dv [3];
    logic [4:0]               r_step;
    logic signed [DW-1:0]     r_prod;
    logic signed [DW-1:0]     r_det [3];
    logic [DW-1:0]            r_num [3];
    logic [DW-1:0]            r_den;
    logic [DW:0]              r_rem;
    logic [WW-1:0]            r_q;
    logic [1:0]               r_sel;
    logic [WW-1:0]            r_w [3];
    logic [1:0]               r_cn, r_ax, r_pax;
    logic signed [DW-1:0]     r_acc [3];
    logic                     r_found;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     in_acc;
    logic signed [COORD_BITS:0] x0, y0, x1, y1, x2, y2, px, py;
    logic signed [COORD_BITS+1:0] n_mul_a, n_mul_b;
    logic signed [DW-1:0]     n_prod;
    logic [2:0]               pstep;
    logic signed [DW:0]       ng;
    logic                     d_pos, in_tri;
    logic [DW:0]              div_shift;
    logic                     last_face;
    logic [WW-1:0]            cw;
    logic [3*COORD_BITS-1:0]  cdv;
    logic signed [COORD_BITS-1:0] ccoord;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Table writes only happen while idle, so no write can overlap a query's reads
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.action == ACT_REST) begin
            rest_mem[i_in_item.index] <= {i_in_item.coord_x, i_in_item.coord_y};
        end
        if (in_acc && i_in_item.action == ACT_DEF) begin
            def_mem[i_in_item.index] <= {i_in_item.coord_x, i_in_item.coord_y,
                                         i_in_item.coord_z};
        end
        if (in_acc && i_in_item.action == ACT_FACE) begin
            face_mem[i_in_item.index] <= {i_in_item.corner_a, i_in_item.corner_b,
                                          i_in_item.corner_c};
        end
        r_face_q <= face_mem[r_face];
        r_rest_q <= rest_mem[rest_addr];
        r_def_q  <= def_mem[def_addr];
    end

    // Select corner addresses for the vertex reads
    always_comb begin
        case (r_state)
            S_VB:    rest_addr = r_face_q[2*VTX_AW-1:VTX_AW];
            S_VC:    rest_addr = r_face_q[VTX_AW-1:0];
            default: rest_addr = r_face_q[3*VTX_AW-1:2*VTX_AW];
        endcase
        case (r_state)
            S_DB:    def_addr = r_cb;
            S_DC:    def_addr = r_cc;
            default: def_addr = r_ca;
        endcase
    end

    // Widen corner coordinates for the differences
    always_comb begin
        x0 = (COORD_BITS+1)'(signed'(r_v[0][2*COORD_BITS-1:COORD_BITS]));
        y0 = (COORD_BITS+1)'(signed'(r_v[0][COORD_BITS-1:0]));
        x1 = (COORD_BITS+1)'(signed'(r_v[1][2*COORD_BITS-1:COORD_BITS]));
        y1 = (COORD_BITS+1)'(signed'(r_v[1][COORD_BITS-1:0]));
        x2 = (COORD_BITS+1)'(signed'(r_v[2][2*COORD_BITS-1:COORD_BITS]));
        y2 = (COORD_BITS+1)'(signed'(r_v[2][COORD_BITS-1:0]));
        px = (COORD_BITS+1)'(r_px);
        py = (COORD_BITS+1)'(r_py);
    end

    // Blend operands: weight of current corner times one deformed coordinate
    always_comb begin
        case (r_cn)
            2'd1:    begin cw = r_w[2]; cdv = r_dv[1]; end
            2'd2:    begin cw = r_w[1]; cdv = r_dv[2]; end
            default: begin cw = r_w[0]; cdv = r_dv[0]; end
        endcase
        case (r_ax)
            2'd1:    ccoord = cdv[2*COORD_BITS-1:COORD_BITS];
            2'd2:    ccoord = cdv[COORD_BITS-1:0];
            default: ccoord = cdv[3*COORD_BITS-1:2*COORD_BITS];
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        if (r_state == S_BLEND) begin
            n_mul_a = signed'({1'b0, cw});
            n_mul_b = (COORD_BITS+2)'(ccoord);
        end else begin
            case (r_step[2:0])
                3'd0: begin n_mul_a = 26'(x1 - x0); n_mul_b = 26'(y2 - y0); end
                3'd1: begin n_mul_a = 26'(y1 - y0); n_mul_b = 26'(x2 - x0); end
                3'd2: begin n_mul_a = 26'(x1 - px); n_mul_b = 26'(y2 - py); end
                3'd3: begin n_mul_a = 26'(y1 - py); n_mul_b = 26'(x2 - px); end
                3'd4: begin n_mul_a = 26'(x1 - x0); n_mul_b = 26'(py - y0); end
                3'd5: begin n_mul_a = 26'(y1 - y0); n_mul_b = 26'(px - x0); end
                default: begin n_mul_a = '0; n_mul_b = '0; end
            endcase
        end
        n_prod = n_mul_a * n_mul_b;
    end

    // Containment test from the determinant signs, plus the division shift and last-face flag
    always_comb begin
        pstep = r_step[2:0] - 3'd1;
        ng = (DW+1)'(r_det[0]) - (DW+1)'(r_det[1]) - (DW+1)'(r_det[2]);
        d_pos = !r_det[0][DW-1];
        if (d_pos) begin
            in_tri = !r_det[1][DW-1] && !r_det[2][DW-1] && !ng[DW];
        end else begin
            in_tri = (r_det[1][DW-1] || r_det[1] == '0)
                  && (r_det[2][DW-1] || r_det[2] == '0)
                  && (ng[DW] || ng == '0);
        end
        div_shift = {r_rem[DW-1:0], 1'b0};
        last_face = ({1'b0, r_face} + FCNT_W'(1)) == r_nfaces;
    end

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_fc <= i_cfg_data;
            end
            // Drop the taken item unless a new one loads in the same cycle
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_item.action == ACT_QUERY) begin
                        r_px     <= i_in_item.coord_x;
                        r_py     <= i_in_item.coord_y;
                        r_face   <= '0;
                        r_found  <= 1'b0;
                        r_nfaces <= (r_fc > FCNT_W'(MAX_FACES)) ? FCNT_W'(MAX_FACES) : r_fc;
                        r_state  <= (r_fc == '0) ? S_DONE : S_FACE;
                    end
                end
                S_FACE: r_state <= S_VA;
                S_VA: begin
                    r_ca    <= r_face_q[3*VTX_AW-1:2*VTX_AW];
                    r_cb    <= r_face_q[2*VTX_AW-1:VTX_AW];
                    r_cc    <= r_face_q[VTX_AW-1:0];
                    r_state <= S_VB;
                end
                S_VB: begin r_v[0] <= r_rest_q; r_state <= S_VC; end
                S_VC: begin r_v[1] <= r_rest_q; r_state <= S_VD; end
                S_VD: begin
                    r_v[2]  <= r_rest_q;
                    r_step  <= '0;
                    r_state <= S_DET;
                end
                // Six products, two per determinant
                S_DET: begin
                    r_prod <= n_prod;
                    if (r_step != '0) begin
                        if (pstep[0]) begin
                            r_det[pstep[2:1]] <= r_det[pstep[2:1]] - r_prod;
                        end else begin
                            r_det[pstep[2:1]] <= r_prod;
                        end
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd6) begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_num[0] <= r_det[1][DW-1] ? DW'(-r_det[1]) : DW'(r_det[1]);
                    r_num[1] <= r_det[2][DW-1] ? DW'(-r_det[2]) : DW'(r_det[2]);
                    r_num[2] <= ng[DW] ? DW'(-ng) : DW'(ng);
                    r_den    <= d_pos ? DW'(r_det[0]) : DW'(-r_det[0]);
                    r_step   <= '0;
                    r_sel    <= '0;
                    if (r_det[0] != '0 && in_tri) begin
                        r_found <= 1'b1;
                        r_state <= S_DIV;
                    end else if (last_face) begin
                        r_state <= S_DONE;
                    end else begin
                        r_face  <= r_face + FACE_AW'(1);
                        r_state <= S_FACE;
                    end
                end
                // Restoring division, one quotient bit per cycle
                S_DIV: begin
                    if (r_step == '0) begin
                        if (r_num[r_sel] >= r_den) begin
                            r_q   <= WW'(1);
                            r_rem <= (DW+1)'(r_num[r_sel] - r_den);
                        end else begin
                            r_q   <= '0;
                            r_rem <= (DW+1)'(r_num[r_sel]);
                        end
                        r_step <= r_step + 5'd1;
                    end else begin
                        if (div_shift >= {1'b0, r_den}) begin
                            r_rem <= div_shift - {1'b0, r_den};
                            r_q   <= {r_q[WW-2:0], 1'b1};
                        end else begin
                            r_rem <= div_shift;
                            r_q   <= {r_q[WW-2:0], 1'b0};
                        end
                        if (r_step == 5'(WFRAC)) begin
                            r_step <= '0;
                            r_w[r_sel] <= (div_shift >= {1'b0, r_den})
                                        ? {r_q[WW-2:0], 1'b1} : {r_q[WW-2:0], 1'b0};
                            r_sel <= r_sel + 2'd1;
                            if (r_sel == 2'd2) begin
                                r_state <= S_DA;
                            end
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end
                end
                S_DA: r_state <= S_DB;
                S_DB: begin r_dv[0] <= r_def_q; r_state <= S_DC; end
                S_DC: begin r_dv[1] <= r_def_q; r_state <= S_DD; end
                S_DD: begin
                    r_dv[2]  <= r_def_q;
                    r_step   <= '0;
                    r_cn     <= '0;
                    r_ax     <= '0;
                    r_acc[0] <= DW'(1) <<< (WFRAC - 1);
                    r_acc[1] <= DW'(1) <<< (WFRAC - 1);
                    r_acc[2] <= DW'(1) <<< (WFRAC - 1);
                    r_state  <= S_BLEND;
                end
                // Nine weighted products, accumulated per axis
                S_BLEND: begin
                    r_prod <= n_prod;
                    r_pax  <= r_ax;
                    if (r_ax == 2'd2) begin
                        r_ax <= '0;
                        r_cn <= r_cn + 2'd1;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                    if (r_step != '0) begin
                        r_acc[r_pax] <= r_acc[r_pax] + r_prod;
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd9) begin
                        r_state <= S_DONE;
                    end
                end
                // Hold until the output register is free
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid    <= 1'b1;
                        r_out.found    <= r_found;
                        r_out.mapped_x <= r_found ? r_acc[0][WFRAC+COORD_BITS-1:WFRAC] : '0;
                        r_out.mapped_y <= r_found ? r_acc[1][WFRAC+COORD_BITS-1:WFRAC] : '0;
                        r_out.mapped_z <= r_found ? r_acc[2][WFRAC+COORD_BITS-1:WFRAC] : '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |->
        (o_out_item.mapped_x == '0 && o_out_item.mapped_y == '0
         && o_out_item.mapped_z == '0))
        else $error("result without a face carries nonzero fields");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("division started on a degenerate face");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DA) |->
        (r_w[0] <= (WW'(1) << WFRAC) && r_w[1] <= (WW'(1) << WFRAC)
         && r_w[2] <= (WW'(1) << WFRAC)))
        else $error("barycentric weight above one");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !(r_out_valid && i_out_stall)) |=> (r_state == S_IDLE))
        else $error("finished query did not return to idle");

endmodule
